### src/midi_clock_sync_divider_defines.svh
// assertion macros for the midi clock sync divider
`ifndef MIDI_CLOCK_SYNC_DIVIDER_DEFINES_SVH
`define MIDI_CLOCK_SYNC_DIVIDER_DEFINES_SVH
`ifndef SYNTHESIS
`define MCSD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MCSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCSD_ASSERT(lbl, clk, rst_n, prop, msg)
`define MCSD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### src/mcsd_pkg.sv
// ----------------------------------------------------------------------------
// mcsd_pkg
// types and constants shared by the midi clock sync divider
// ----------------------------------------------------------------------------
`default_nettype none
package mcsd_pkg;
    localparam logic [1:0] REQ_TIMER = 2'd0;
    localparam logic [1:0] REQ_MIDI  = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;
    localparam logic [1:0] REQ_STOP  = 2'd3;

    localparam logic [7:0] MIDI_CLOCK    = 8'hF8;
    localparam logic [7:0] MIDI_START    = 8'hFA;
    localparam logic [7:0] MIDI_CONTINUE = 8'hFB;
    localparam logic [7:0] MIDI_STOP     = 8'hFC;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_MASTER = 2'd1;
    localparam logic [1:0] MODE_SLAVE  = 2'd2;

    localparam logic [1:0] CFG_TIMER_PERIOD = 2'd0;
    localparam logic [1:0] CFG_SLAVE_DIV    = 2'd1;
    localparam logic [1:0] CFG_OUT_DIV      = 2'd2;
    localparam logic [1:0] CFG_PULSE_LEN    = 2'd3;

    localparam logic [31:0] SILENCE_US = 32'd500000;
    localparam logic [31:0] LATE_US    = 32'd1000;
    localparam int unsigned RESET_SPAN = 48 * 8;

    // classified command from the front end
    typedef enum logic [2:0] {
        CMD_NONE, CMD_TIMER, CMD_CLOCK, CMD_SSTART, CMD_SCONT, CMD_SSTOP,
        CMD_MSTART, CMD_MSTOP
    } t_cmd;

    typedef struct packed {
        logic        tick_fired;
        logic [31:0] tick_count;
        logic        clock_level;
        logic        clock_changed;
        logic        reset_trigger;
        logic [1:0]  run_mode;
        logic        start_event;
        logic        stop_event;
    } t_result;
endpackage
`default_nettype wire

### src/mcsd_if.sv
// ----------------------------------------------------------------------------
// mcsd_req_if / mcsd_res_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
`default_nettype none
interface mcsd_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] midi_byte;
    modport source (output valid, output req_type, output midi_byte, input ready);
    modport sink (input valid, input req_type, input midi_byte, output ready);
endinterface

interface mcsd_res_if;
    logic        valid;
    logic        ready;
    logic        tick_fired;
    logic [31:0] tick_count;
    logic        clock_level;
    logic        clock_changed;
    logic        reset_trigger;
    logic [1:0]  run_mode;
    logic        start_event;
    logic        stop_event;
    modport source (output valid, output tick_fired, output tick_count, output clock_level,
        output clock_changed, output reset_trigger, output run_mode, output start_event,
        output stop_event, input ready);
    modport sink (input valid, input tick_fired, input tick_count, input clock_level,
        input clock_changed, input reset_trigger, input run_mode, input start_event,
        input stop_event, output ready);
endinterface
`default_nettype wire

### src/mcsd_front.sv
// ----------------------------------------------------------------------------
// mcsd_front
// accepts request beats, classifies them and queues commands (two entries)
// ----------------------------------------------------------------------------
`default_nettype none
module mcsd_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire  [1:0]        i_req_type,
    input  wire  [7:0]        i_midi_byte,
    output logic              o_cmd_valid,
    output mcsd_pkg::t_cmd    o_cmd,
    input  wire               i_cmd_pop
);
    mcsd_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    mcsd_pkg::t_cmd w_cls;
    logic           w_push;

    // classify
    always_comb begin
        case (i_req_type)
            mcsd_pkg::REQ_TIMER: w_cls = mcsd_pkg::CMD_TIMER;
            mcsd_pkg::REQ_START: w_cls = mcsd_pkg::CMD_MSTART;
            mcsd_pkg::REQ_STOP:  w_cls = mcsd_pkg::CMD_MSTOP;
            default: begin
                case (i_midi_byte)
                    mcsd_pkg::MIDI_CLOCK:    w_cls = mcsd_pkg::CMD_CLOCK;
                    mcsd_pkg::MIDI_START:    w_cls = mcsd_pkg::CMD_SSTART;
                    mcsd_pkg::MIDI_CONTINUE: w_cls = mcsd_pkg::CMD_SCONT;
                    mcsd_pkg::MIDI_STOP:     w_cls = mcsd_pkg::CMD_SSTOP;
                    default:                 w_cls = mcsd_pkg::CMD_NONE;
                endcase
            end
        endcase
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cls;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_cmd_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_cmd_pop};
        end
    end
endmodule
`default_nettype wire

### src/mcsd_div.sv
// ----------------------------------------------------------------------------
// mcsd_div
// iterative restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module mcsd_div (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [31:0] i_num,
    input  wire  [31:0] i_den,
    output logic        o_busy,
    output logic [31:0] o_quo
);
    logic [31:0] r_quo, r_den;
    logic [32:0] r_rem;
    logic [5:0]  r_cnt;
    logic [32:0] w_sh;
    logic [33:0] w_diff;

    assign o_busy = (r_cnt != 6'd0);
    assign o_quo  = r_quo;
    assign w_sh   = {r_rem[31:0], r_quo[31]};
    assign w_diff = {1'b0, w_sh} - {2'b00, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 6'd0;
        end else if (i_start) begin
            r_cnt <= 6'd32;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num; r_den <= i_den; r_rem <= 33'd0;
        end else if (o_busy) begin
            if (!w_diff[33]) begin
                r_rem <= w_diff[32:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

### src/mcsd_back.sv
// ----------------------------------------------------------------------------
// mcsd_back
// executes commands: mode control, sub-tick scheduling, output divider
// ----------------------------------------------------------------------------
`default_nettype none
`include "midi_clock_sync_divider_defines.svh"
module mcsd_back #(
    parameter int unsigned PPQN = 192
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cmd_valid,
    input  mcsd_pkg::t_cmd     i_cmd,
    output logic               o_cmd_pop,
    input  wire  [15:0]        i_timer_period_us,
    input  wire  [6:0]         i_slave_divisor,
    input  wire  [12:0]        i_out_divisor,
    input  wire  [12:0]        i_pulse_len_ticks,
    output logic               o_res_valid,
    input  wire                i_res_ready,
    output mcsd_pkg::t_result  o_res
);
    // 120 bpm period per divisor unit: 60e6/(120*PPQN)
    localparam int unsigned DefNum = 60000000;
    localparam int unsigned DefDen = 120 * PPQN;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_TICK  = 3'd3;
    localparam logic [2:0] ST_GATE  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;
    localparam logic [2:0] ST_DDIV  = 3'd6;

    logic [2:0]  r_st;
    logic [1:0]  r_mode;
    logic [31:0] r_ticks, r_el, r_last, r_next, r_sub, r_per;
    logic [31:0] r_ndiv, r_on, r_off;
    logic [7:0]  r_pend;
    logic [8:0]  r_span;
    logic        r_gate, r_fired, r_chg, r_rst_tr, r_sev, r_pev, r_mod;
    logic        r_ov;
    logic        w_out_busy, w_div_start, w_div_busy;
    logic [31:0] w_div_num, w_div_den, w_div_q;
    logic [6:0]  w_div7;
    logic [8:0]  w_sum, w_cap;
    logic [31:0] w_gap, w_el_t, w_a, w_b;
    logic        w_is384;
    mcsd_pkg::t_result r_res;

    assign w_div7  = (i_slave_divisor == 7'd0) ? 7'd1 : i_slave_divisor;
    assign w_sum   = {1'b0, r_pend} + {2'b00, w_div7};
    assign w_cap   = {1'b0, w_div7, 1'b0};
    assign w_gap   = r_el - r_last;
    assign w_el_t  = r_el + {16'd0, i_timer_period_us};
    assign w_a     = r_ndiv + {19'd0, (i_pulse_len_ticks == 13'd0) ? 13'd1 : i_pulse_len_ticks};
    assign w_b     = r_ndiv + {19'd0, i_out_divisor} - 32'd1;
    // tick count modulo the reset span is tracked alongside the counter
    assign w_is384 = (r_span == 9'd0);

    assign w_out_busy = o_res_valid && !i_res_ready;
    assign o_cmd_pop  = (r_st == ST_IDLE) && i_cmd_valid && !w_out_busy;
    assign o_res_valid = r_ov;

    // divider shared by default-period and sub-period computation
    mcsd_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_div_num), .i_den(w_div_den), .o_busy(w_div_busy), .o_quo(w_div_q)
    );
    assign w_div_start = (r_st == ST_DDIV) || (r_st == ST_DIV);
    assign w_div_num = (r_st == ST_DDIV) ? DefNum * {25'd0, w_div7} : r_per;
    assign w_div_den = (r_st == ST_DDIV) ? 32'(DefDen) : {24'd0, r_pend};

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_mode <= mcsd_pkg::MODE_IDLE; r_ticks <= '0; r_el <= '0;
            r_last <= '0; r_next <= '0; r_sub <= '0; r_per <= '0; r_pend <= '0;
            r_ndiv <= '0; r_on <= '0; r_off <= '0; r_gate <= 1'b0;
            r_fired <= 1'b0; r_chg <= 1'b0; r_rst_tr <= 1'b0; r_sev <= 1'b0;
            r_pev <= 1'b0; r_mod <= 1'b0; r_span <= '0;
        end else begin
            case (r_st)
                ST_IDLE: begin
                    if (o_cmd_pop) begin
                        r_fired <= 1'b0; r_chg <= 1'b0; r_rst_tr <= 1'b0;
                        r_sev <= 1'b0; r_pev <= 1'b0;
                        r_st <= ST_OUT;
                        case (i_cmd)
                            mcsd_pkg::CMD_TIMER: begin
                                if (r_mode == mcsd_pkg::MODE_MASTER) begin
                                    r_el <= w_el_t; r_st <= ST_TICK;
                                end else if (r_mode == mcsd_pkg::MODE_SLAVE) begin
                                    r_el <= w_el_t;
                                    if (r_pend != 8'd0 && w_el_t >= r_next) begin
                                        r_pend <= r_pend - 8'd1;
                                        r_next <= r_next + r_sub;
                                        // silence drop is applied after the tick
                                        r_mod <= (w_el_t - r_last > mcsd_pkg::SILENCE_US);
                                        r_st <= ST_TICK;
                                    end else if (w_el_t - r_last > mcsd_pkg::SILENCE_US) begin
                                        r_mode <= mcsd_pkg::MODE_IDLE;
                                    end
                                end
                            end
                            mcsd_pkg::CMD_CLOCK: begin
                                if (r_mode == mcsd_pkg::MODE_SLAVE) begin
                                    r_pend <= (w_sum < w_cap) ? w_sum[7:0] : w_cap[7:0];
                                    if (w_gap != 32'd0 && r_last != 32'd0) begin
                                        r_per <= w_gap; r_st <= ST_DIV;
                                    end else if (r_per == 32'd0) begin
                                        r_st <= ST_DDIV;
                                    end else begin
                                        r_st <= ST_DIV;
                                    end
                                end
                            end
                            mcsd_pkg::CMD_SSTART: begin
                                if (r_mode != mcsd_pkg::MODE_MASTER) begin
                                    r_mode <= mcsd_pkg::MODE_SLAVE; r_ticks <= '0;
                                    r_pend <= '0; r_ndiv <= '0; r_el <= '0;
                                    r_last <= '0; r_sev <= 1'b1; r_span <= '0;
                                end
                            end
                            mcsd_pkg::CMD_SCONT: begin
                                if (r_mode == mcsd_pkg::MODE_IDLE) begin
                                    r_mode <= mcsd_pkg::MODE_SLAVE; r_el <= '0; r_last <= '0;
                                end
                            end
                            mcsd_pkg::CMD_SSTOP: begin
                                if (r_mode == mcsd_pkg::MODE_SLAVE) begin
                                    r_mode <= mcsd_pkg::MODE_IDLE; r_pev <= 1'b1;
                                end
                            end
                            mcsd_pkg::CMD_MSTART: begin
                                r_mode <= mcsd_pkg::MODE_MASTER; r_ticks <= '0;
                                r_pend <= '0; r_ndiv <= '0; r_el <= '0; r_span <= '0;
                            end
                            mcsd_pkg::CMD_MSTOP: r_mode <= mcsd_pkg::MODE_IDLE;
                            default: ;
                        endcase
                    end
                end
                ST_DDIV: begin
                    r_st <= ST_WAIT;
                    r_mod <= 1'b1;
                end
                ST_DIV: r_st <= ST_WAIT;
                ST_WAIT: begin
                    if (!w_div_busy) begin
                        if (r_mod) begin
                            // default period ready, now the sub-period
                            r_mod <= 1'b0;
                            r_per <= w_div_q;
                            r_st <= ST_DIV;
                        end else begin
                            r_sub <= w_div_q;
                            if (r_el - r_next > mcsd_pkg::LATE_US) r_next <= r_el;
                            else r_next <= r_next + w_div_q;
                            r_last <= r_el;
                            r_st <= ST_OUT;
                        end
                    end
                end
                ST_TICK: begin
                    // divider schedule step
                    if (r_ticks == r_ndiv) begin
                        r_on <= r_ndiv;
                        r_off <= (w_a < w_b) ? w_a : w_b;
                        r_ndiv <= r_ndiv + {19'd0, i_out_divisor};
                    end
                    r_st <= ST_GATE;
                end
                ST_GATE: begin
                    // gate level update, then count
                    if (r_ticks == r_off && (r_ticks == r_on || r_gate)) begin
                        if (r_gate) begin
                            r_chg <= 1'b1; r_rst_tr <= w_is384;
                        end
                        r_gate <= 1'b0;
                    end else if (r_ticks == r_on && !r_gate) begin
                        r_gate <= 1'b1; r_chg <= 1'b1; r_rst_tr <= w_is384;
                    end
                    if (r_ticks == r_on && r_ticks == r_off && !r_gate) begin
                        r_chg <= 1'b1; r_rst_tr <= w_is384;
                    end
                    r_ticks <= r_ticks + 32'd1;
                    r_span <= (r_span == 9'(mcsd_pkg::RESET_SPAN - 1)) ? 9'd0 : r_span + 9'd1;
                    r_fired <= 1'b1;
                    if (r_mod) begin
                        r_mode <= mcsd_pkg::MODE_IDLE; r_mod <= 1'b0;
                    end
                    r_st <= ST_OUT;
                end
                ST_OUT: begin
                    r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_st == ST_OUT) begin
            r_ov <= 1'b1;
        end else if (i_res_ready) begin
            r_ov <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (r_st == ST_OUT) begin
            r_res.tick_fired    <= r_fired;
            r_res.tick_count    <= r_ticks;
            r_res.clock_level   <= r_gate;
            r_res.clock_changed <= r_chg;
            r_res.reset_trigger <= r_rst_tr;
            r_res.run_mode      <= r_mode;
            r_res.start_event   <= r_sev;
            r_res.stop_event    <= r_pev;
        end
    end
    assign o_res = r_res;

    // assertions
    `MCSD_ASSERT(a_pop_idle, i_clk, i_rst_n, o_cmd_pop |-> !r_ov || i_res_ready,
        "command taken while result stalled")
    `MCSD_ASSERT(a_trig_chg, i_clk, i_rst_n, r_ov |-> !r_res.reset_trigger || r_res.clock_changed,
        "reset trigger without clock change")
    `MCSD_ASSERT(a_mode_ok, i_clk, i_rst_n, r_mode != 2'd3, "illegal run mode")
endmodule
`default_nettype wire

### src/midi_clock_sync_divider.sv
// ----------------------------------------------------------------------------
// midi_clock_sync_divider
// master/slave tempo clock with MIDI sync and gated output divider
// ----------------------------------------------------------------------------
// usage: requests (timer tick, MIDI byte, master start/stop) enter on i_req,
// one result beat leaves on o_res for every request beat, in order.
// the user must write the configuration registers through i_cfg_we/i_cfg_idx/
// i_cfg_data only while the block is idle; the block does not enforce this.
// a request passes the queue and the back end states idle and out before its
// result is registered; a firing tick adds the tick and gate states; a MIDI
// clock byte in slave mode runs the shared serial divider for the sub-tick
// period, twice when it is still zero and the 120 bpm default comes first.
// one request is executed at a time; a two-beat command queue decouples the
// input side, so requests are taken while the back end works.
// reset clears mode to idle, all counters and times to zero, gate low, and
// registers to 100 us, divisor 8, out divisor 48, pulse length 1.
// when the receiver stalls, the finished result holds and the back end
// waits; the queue fills and then i_req.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none
module midi_clock_sync_divider #(
    parameter int unsigned PPQN = 192
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    mcsd_req_if.sink    i_req,
    mcsd_res_if.source  o_res,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [15:0] i_cfg_data
);
    logic [15:0] r_tp;
    logic [6:0]  r_sd;
    logic [12:0] r_od, r_pl;
    logic        w_cv, w_pop, w_rv;
    mcsd_pkg::t_cmd    w_cmd;
    mcsd_pkg::t_result w_res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tp <= 16'd100; r_sd <= 7'd8; r_od <= 13'd48; r_pl <= 13'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mcsd_pkg::CFG_TIMER_PERIOD: r_tp <= i_cfg_data;
                mcsd_pkg::CFG_SLAVE_DIV:    r_sd <= i_cfg_data[6:0];
                mcsd_pkg::CFG_OUT_DIV:      r_od <= i_cfg_data[12:0];
                mcsd_pkg::CFG_PULSE_LEN:    r_pl <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    mcsd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_req.valid), .o_ready(i_req.ready),
        .i_req_type(i_req.req_type), .i_midi_byte(i_req.midi_byte),
        .o_cmd_valid(w_cv), .o_cmd(w_cmd), .i_cmd_pop(w_pop)
    );

    mcsd_back #(.PPQN(PPQN)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(w_cv), .i_cmd(w_cmd),
        .o_cmd_pop(w_pop), .i_timer_period_us(r_tp), .i_slave_divisor(r_sd),
        .i_out_divisor(r_od), .i_pulse_len_ticks(r_pl), .o_res_valid(w_rv),
        .i_res_ready(o_res.ready), .o_res(w_res)
    );

    assign o_res.valid         = w_rv;
    assign o_res.tick_fired    = w_res.tick_fired;
    assign o_res.tick_count    = w_res.tick_count;
    assign o_res.clock_level   = w_res.clock_level;
    assign o_res.clock_changed = w_res.clock_changed;
    assign o_res.reset_trigger = w_res.reset_trigger;
    assign o_res.run_mode      = w_res.run_mode;
    assign o_res.start_event   = w_res.start_event;
    assign o_res.stop_event    = w_res.stop_event;
endmodule
`default_nettype wire
